[rtl/sha256_pkg.sv]
// Package: SHA-256 constants, round functions and the front-to-back command type.
`default_nettype none
package sha256_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = 2;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       eom;
    } t_cmd;

    typedef logic [31:0] t_word;

    function automatic t_word round_k(input logic [5:0] t);
        t_word k;
        begin
            unique case (t)
                6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
                6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
                6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
                6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
                6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic t_word init_h(input logic [2:0] i);
        t_word h;
        begin
            unique case (i)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
                default: h = 32'h0;
            endcase
            return h;
        end
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

[rtl/sha256_if.sv]
// Interfaces: valid/ready channels for input beats and digest beats.
`default_nettype none
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
    modport source(output valid, msg_byte, byte_present, end_of_message, input ready);
    modport sink(input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source(output valid, digest_word, word_index, last_word, input ready);
    modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

[rtl/sha256_front.sv]
// Front end: accept input beats, drop empty ones, queue the rest for the core.
`default_nettype none
module sha256_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    sha256_in_if.sink           in_ch,
    output sha256_pkg::t_cmd    o_cmd,
    output logic                o_cmd_valid,
    input  wire                 i_cmd_pop
);
    sha256_pkg::t_cmd r_q [sha256_pkg::QueueDepth];
    logic [sha256_pkg::QueuePtrW-1:0] r_wr, r_rd;
    logic [sha256_pkg::QueuePtrW:0]   r_cnt;
    logic acc, push, pop;

    assign in_ch.ready = !r_cnt[sha256_pkg::QueuePtrW];
    assign acc  = in_ch.valid && in_ch.ready;
    assign push = acc && (in_ch.byte_present || in_ch.end_of_message);
    assign pop  = i_cmd_pop && o_cmd_valid;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= '{data: in_ch.msg_byte, present: in_ch.byte_present,
                           eom: in_ch.end_of_message};
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
        end
    end
endmodule
`default_nettype wire

[rtl/sha256_core.sv]
// Back end: byte packing, padding sequencer, round engine and digest output.
`default_nettype none
module sha256_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  sha256_pkg::t_cmd    i_cmd,
    input  wire                 i_cmd_valid,
    output logic                o_cmd_pop,
    sha256_out_if.source        out_ch
);
    typedef enum logic [2:0] {S_IDLE, S_PAD, S_LEN, S_ROUND, S_FOLD, S_OUT} t_state;
    typedef sha256_pkg::t_word t_word;

    t_state      r_state, r_after;
    t_word       r_w [16];
    t_word       r_h [8];
    t_word       r_v [8];
    logic [5:0]  r_pos, r_round;
    logic [63:0] r_bits, r_len;
    logic [2:0]  r_lenb, r_oidx;
    logic        r_ovalid;

    logic        byte_en;
    logic [7:0]  byte_val;
    logic        blk_full;
    t_word       wt, x2, x15, s0, s1, t1, t2, big0, big1, ch, maj;
    logic [3:0]  ti;

    always_comb begin
        byte_en  = 1'b0;
        byte_val = 8'h00;
        o_cmd_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                byte_en   = i_cmd_valid && i_cmd.present;
                byte_val  = i_cmd.data;
            end
            S_PAD: begin
                byte_en  = 1'b1;
                byte_val = (r_lenb == 3'd0) ? 8'h80 : 8'h00;
            end
            S_LEN: begin
                byte_en  = 1'b1;
                byte_val = r_len[63:56];
            end
            default: ;
        endcase
        blk_full = byte_en && (r_pos == 6'd63);
    end

    assign ti  = r_round[3:0];
    assign x2  = r_w[ti - 4'd2];
    assign x15 = r_w[ti - 4'd15];
    assign s1  = sha256_pkg::rotr(x2, 17) ^ sha256_pkg::rotr(x2, 19) ^ (x2 >> 10);
    assign s0  = sha256_pkg::rotr(x15, 7) ^ sha256_pkg::rotr(x15, 18) ^ (x15 >> 3);
    assign wt  = (r_round < 6'd16) ? r_w[ti] : s1 + r_w[ti - 4'd7] + s0 + r_w[ti];
    assign big1 = sha256_pkg::rotr(r_v[4], 6) ^ sha256_pkg::rotr(r_v[4], 11)
                ^ sha256_pkg::rotr(r_v[4], 25);
    assign ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign big0 = sha256_pkg::rotr(r_v[0], 2) ^ sha256_pkg::rotr(r_v[0], 13)
                ^ sha256_pkg::rotr(r_v[0], 22);
    assign maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1   = r_v[7] + big1 + ch + sha256_pkg::round_k(r_round) + wt;
    assign t2   = big0 + maj;

    assign out_ch.valid       = r_ovalid;
    assign out_ch.digest_word = r_h[r_oidx];
    assign out_ch.word_index  = r_oidx;
    assign out_ch.last_word   = (r_oidx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (byte_en) r_w[r_pos[5:2]] <= {r_w[r_pos[5:2]][23:0], byte_val};
        if (r_state == S_ROUND) begin
            r_w[ti] <= wt;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (blk_full) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_after  <= S_IDLE;
            r_pos    <= '0;
            r_round  <= '0;
            r_bits   <= '0;
            r_len    <= '0;
            r_lenb   <= '0;
            r_oidx   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::init_h(3'(i));
        end else begin
            if (byte_en) r_pos <= r_pos + 1'b1;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.present) r_bits <= r_bits + 64'd8;
                        r_len  <= r_bits + (i_cmd.present ? 64'd8 : 64'd0);
                        r_lenb <= '0;
                        if (blk_full) begin
                            r_state <= S_ROUND;
                            r_after <= i_cmd.eom ? S_PAD : S_IDLE;
                        end else if (i_cmd.eom) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_lenb <= 3'd1;
                    if (blk_full) begin
                        r_state <= S_ROUND;
                        r_after <= S_PAD;
                    end else if (r_pos == 6'd55) begin
                        r_state <= S_LEN;
                        r_lenb  <= '0;
                    end
                end
                S_LEN: begin
                    r_len  <= {r_len[55:0], 8'h00};
                    r_lenb <= r_lenb + 1'b1;
                    if (blk_full) begin
                        r_state <= S_ROUND;
                        r_after <= S_OUT;
                    end
                end
                S_ROUND: begin
                    r_round <= r_round + 1'b1;
                    if (r_round == 6'd63) r_state <= S_FOLD;
                end
                S_FOLD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_state <= r_after;
                    if (r_after == S_OUT) begin
                        r_ovalid <= 1'b1;
                        r_oidx   <= '0;
                    end
                end
                S_OUT: begin
                    if (out_ch.ready) begin
                        r_oidx <= r_oidx + 1'b1;
                        if (r_oidx == 3'd7) begin
                            r_ovalid <= 1'b0;
                            r_state  <= S_IDLE;
                            r_bits   <= '0;
                            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::init_h(3'(i));
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/sha256_byte_stream_hasher.sv]
// Top level: SHA-256 hasher fed one message byte per beat, emitting eight digest beats.
//
// Input channel in_ch: one beat per byte (msg_byte, byte_present) with
// end_of_message on the last beat; an end beat with no byte is allowed.
// Beats with neither flag set are dropped in the front end.
// A four-entry queue decouples the front end from the compression core,
// which takes one queued beat per cycle while loading a block.
// Each full 64-byte block is compressed in the round state and folded into
// the hash in the fold state, during which the core takes no beats; the
// queue keeps accepting until full. After end_of_message the core pads
// (one or two extra compressions), then presents digest words 0..7 on
// out_ch, one per cycle while the receiver takes them; a stalled receiver
// holds the current word and the core waits. From the end beat to the
// first word, with the queue otherwise empty, the beat passes through the
// queue, the padding and length bytes are loaded, and each final block
// is compressed and folded.
// Reset (i_rst_n low, synchronous) empties the queue, restores the
// initial hash values and clears the byte and bit counters.
`default_nettype none
module sha256_byte_stream_hasher (
    input  wire          i_clk,
    input  wire          i_rst_n,
    sha256_in_if.sink    in_ch,
    sha256_out_if.source out_ch
);
    sha256_pkg::t_cmd cmd;
    logic cmd_valid, cmd_pop;

    sha256_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_cmd(cmd), .o_cmd_valid(cmd_valid), .i_cmd_pop(cmd_pop)
    );

    sha256_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_cmd_valid(cmd_valid),
        .o_cmd_pop(cmd_pop), .out_ch(out_ch)
    );

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid) else $error("pop from empty queue");
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> (out_ch.last_word == (out_ch.word_index == 3'd7)))
        else $error("last_word mismatch");
    a_out_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.ready && !out_ch.last_word) |=>
        (out_ch.valid && out_ch.word_index == $past(out_ch.word_index) + 3'd1))
        else $error("digest word sequence broken");
endmodule
`default_nettype wire

[tb/sv/sha256_byte_stream_hasher_tb.sv]
// Testbench: byte-stream SHA-256 hasher checked against a behavioral digest predictor.
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hasher_tb;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    class digest_scoreboard;
        logic [31:0] h_st[8];
        logic [31:0] blk[16];
        int unsigned pos;
        logic [63:0] bits;
        t_digest_beat pending[$];
        int unsigned errors;
        int unsigned messages;
        int unsigned words_seen;

        function new();
            errors = 0;
            messages = 0;
            words_seen = 0;
            foreach (blk[i]) blk[i] = '0;
            restart();
        endfunction

        function void restart();
            h_st[0] = 32'h6a09e667; h_st[1] = 32'hbb67ae85;
            h_st[2] = 32'h3c6ef372; h_st[3] = 32'ha54ff53a;
            h_st[4] = 32'h510e527f; h_st[5] = 32'h9b05688c;
            h_st[6] = 32'h1f83d9ab; h_st[7] = 32'h5be0cd19;
            pos = 0;
            bits = '0;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function logic [31:0] kconst(int t);
            logic [31:0] k[64];
            k = '{
                32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
                32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
                32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
                32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
                32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
                32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
                32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
                32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
                32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
                32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
                32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
                32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
                32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
            return k[t];
        endfunction

        function void compress();
            logic [31:0] v[8];
            logic [31:0] w, s0, s1, t1, t2;
            for (int i = 0; i < 8; i++) v[i] = h_st[i];
            for (int t = 0; t < 64; t++) begin
                if (t < 16) begin
                    w = blk[t];
                end else begin
                    s1 = ror(blk[(t - 2) & 15], 17) ^ ror(blk[(t - 2) & 15], 19)
                        ^ (blk[(t - 2) & 15] >> 10);
                    s0 = ror(blk[(t - 15) & 15], 7) ^ ror(blk[(t - 15) & 15], 18)
                        ^ (blk[(t - 15) & 15] >> 3);
                    w = s1 + blk[(t - 7) & 15] + s0 + blk[t & 15];
                    blk[t & 15] = w;
                end
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                    + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(t) + w;
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                    + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) h_st[i] += v[i];
        endfunction

        function void absorb(logic [7:0] b);
            blk[pos >> 2] = ((pos & 3) == 0) ? {24'h0, b} : {blk[pos >> 2][23:0], b};
            pos = (pos + 1) & 63;
            if (pos == 0) compress();
        endfunction

        function void note_input(logic [7:0] b, logic present, logic eom);
            logic [63:0] len;
            t_digest_beat e;
            if (present) begin
                absorb(b);
                bits += 64'd8;
            end
            if (eom) begin
                len = bits;
                absorb(8'h80);
                while (pos != 56) absorb(8'h00);
                for (int i = 7; i >= 0; i--) absorb(len[i*8 +: 8]);
                for (int i = 0; i < 8; i++) begin
                    e.word = h_st[i];
                    e.index = i[2:0];
                    e.last = (i == 7);
                    pending = {pending, e};
                end
                messages++;
                restart();
            end
        endfunction

        function void check_output(logic [31:0] w, logic [2:0] idx, logic last);
            t_digest_beat e;
            words_seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected digest beat word=%h idx=%0d last=%b",
                    $time, w, idx, last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (w !== e.word || idx !== e.index || last !== e.last) begin
                $display("%0t: digest mismatch exp word=%h idx=%0d last=%b",
                    $time, e.word, e.index, e.last,
                    " got word=%h idx=%0d last=%b", w, idx, last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    sha256_in_if  in_ch ();
    sha256_out_if out_ch ();

    sha256_byte_stream_hasher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    digest_scoreboard sb;
    bit quiet_phase;
    int unsigned beats_sent;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    // Sample both channels at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                sb.note_input(in_ch.msg_byte, in_ch.byte_present, in_ch.end_of_message);
            if (out_ch.valid && out_ch.ready)
                sb.check_output(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
        end
    end

    // Receiver: random stall bursts, none late in the run.
    initial begin
        int n;
        out_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 6);
                out_ch.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    task automatic send_beat(logic [7:0] b, logic present, logic eom);
        int n;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.msg_byte <= b;
        in_ch.byte_present <= present;
        in_ch.end_of_message <= eom;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        beats_sent++;
    endtask

    task automatic send_message(int len, int mode, bit eom_byte);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: b = 8'($urandom_range(0, 255));
                1: b = 8'h00;
                2: b = 8'hff;
                default: b = 8'(8'h61 + i % 3);
            endcase
            if (eom_byte && i == len - 1) begin
                send_beat(b, 1'b1, 1'b1);
                return;
            end
            send_beat(b, 1'b1, 1'b0);
            if ($urandom_range(0, 15) == 0)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    initial begin
        int len;
        sb = new();
        quiet_phase = 1'b0;
        beats_sent = 0;
        in_ch.valid = 1'b0;
        in_ch.msg_byte = '0;
        in_ch.byte_present = 1'b0;
        in_ch.end_of_message = 1'b0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_beat(8'h00, 1'b0, 1'b1);
        send_message(3, 3, 1'b0);
        send_message(3, 3, 1'b1);
        send_beat(8'h5a, 1'b0, 1'b0);
        send_message(1, 1, 1'b1);
        send_message(1, 2, 1'b0);
        send_message(4, 0, 1'b1);
        drain();

        // Padding boundaries: 55, 56, 63, 64 bytes.
        send_message(55, 0, 1'b0);
        send_message(56, 2, 1'b1);
        send_message(63, 1, 1'b0);
        send_message(64, 0, 1'b1);
        drain();

        while (beats_sent < 460) begin
            if (beats_sent > 380) quiet_phase = 1'b1;
            case ($urandom_range(0, 9))
                0: len = 0;
                1: len = $urandom_range(54, 66);
                2: len = $urandom_range(100, 130);
                default: len = $urandom_range(1, 20);
            endcase
            send_message(len, $urandom_range(0, 5) < 4 ? 0 : $urandom_range(1, 3),
                len > 0 && $urandom_range(0, 1));
        end
        drain();
        repeat (200) @(negedge i_clk);

        $display("Hashed %0d messages over %0d input beats, %0d digest words checked.",
            sb.messages, beats_sent, sb.words_seen);
        $display("Lengths covered empty, short, padding edges and multi-block cases.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
rtl/sha256_pkg.sv
rtl/sha256_if.sv
rtl/sha256_front.sv
rtl/sha256_core.sv
rtl/sha256_byte_stream_hasher.sv
tb/sv/sha256_byte_stream_hasher_tb.sv
